// File: hw/rtl/che_pkg.sv
// Shared types and constants for the cubic Hermite segment evaluator.
// No dependencies; every other file imports this package.
`default_nettype none
package che_pkg;
  localparam int DataW    = 32;
  localparam int CoefW    = 64;
  localparam int FracBits = 16;
  localparam int NumRegs  = 6;
  localparam int RegIdxW  = 3;
  localparam int LenW     = 6;

  localparam logic [RegIdxW-1:0] RegXStart     = 3'd0;
  localparam logic [RegIdxW-1:0] RegYStart     = 3'd1;
  localparam logic [RegIdxW-1:0] RegSlopeStart = 3'd2;
  localparam logic [RegIdxW-1:0] RegXEnd       = 3'd3;
  localparam logic [RegIdxW-1:0] RegYEnd       = 3'd4;
  localparam logic [RegIdxW-1:0] RegSlopeEnd   = 3'd5;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StEqual = 2'd1;
  localparam logic [1:0] StSat   = 2'd2;

  typedef struct packed {
    logic                    done;
    logic                    eq;
    logic signed [DataW-1:0] xl;
    logic signed [DataW-1:0] xh;
    logic [LenW-1:0]         len;
    logic [3:0][CoefW-1:0]   coef;
  } seg_t;

  typedef struct packed {
    logic signed [CoefW-1:0] acc;
    logic signed [CoefW-1:0] u;
    logic                    inr;
    logic                    sat;
  } hstage_t;
endpackage
`default_nettype wire

// File: hw/rtl/che_if.sv
// Request and result channel interfaces with valid/ready handshake.
// Depends on che_pkg for field widths.
`default_nettype none
interface query_if import che_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] query_x;
  modport source (output valid, query_x, input ready);
  modport sink   (input valid, query_x, output ready);
endinterface

interface result_if import che_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] value_y;
  logic                    in_range;
  logic [1:0]              status;
  modport source (output valid, value_y, in_range, status, input ready);
  modport sink   (input valid, value_y, in_range, status, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/che_solve.sv
// Configuration registers and the segment solver: orders the endpoints and
// solves the four coefficients with a bit-serial divider. Depends on che_pkg.
`default_nettype none
module che_solve import che_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [RegIdxW-1:0] cfg_index,
  input  logic [DataW-1:0]   cfg_data,
  output seg_t               seg
);
  localparam int DivSteps = 128;
  localparam int CntW     = $clog2(DivSteps);

  typedef enum logic [2:0] {
    ST_ORDER, ST_LEN, ST_NUM, ST_DLOAD, ST_DIV, ST_DFIX, ST_ROUND, ST_DONE
  } state_t;

  state_t                  state;
  logic [DataW-1:0]        regs [NumRegs];
  logic                    eq;
  logic signed [DataW-1:0] xl, xh, yl, yh, ml, mh;
  logic [LenW-1:0]         len;
  logic [3:0][CoefW-1:0]   coef;
  logic [DataW-1:0]        h;
  logic signed [DataW:0]   d;
  logic [1:0]              k, pass;
  logic signed [127:0]     z;
  logic [127:0]            num;
  logic [DataW-1:0]        rem;
  logic [CntW-1:0]         cnt;
  logic                    neg;

  logic                    cfg_hit, flip, eq_next, ge;
  logic signed [DataW:0]   hx;
  logic [LenW-1:0]         len_next;
  logic signed [DataW+1:0] ma;
  logic signed [66:0]      prod;
  logic signed [69:0]      ds, n;
  logic [127:0]            zmag, qfix;
  logic [DataW:0]          trial, diff;
  logic signed [127:0]     r;
  logic                    fits;

  assign cfg_hit = cfg_we && (cfg_index < RegIdxW'(NumRegs));
  assign flip    = $signed(regs[RegXStart]) > $signed(regs[RegXEnd]);
  assign eq_next = regs[RegXStart] == regs[RegXEnd];
  assign hx      = (DataW+1)'(xh) - (DataW+1)'(xl);

  always_comb begin
    len_next = '0;
    for (int i = 0; i < DataW; i++) begin
      if (hx[i]) len_next = LenW'(i + 1);
    end
  end

  always_comb begin
    case (k)
      2'd1:    ma = (DataW+2)'(ml);
      2'd2:    ma = ((DataW+2)'(ml) <<< 1) + (DataW+2)'(mh);
      2'd3:    ma = (DataW+2)'(ml) + (DataW+2)'(mh);
      default: ma = (DataW+2)'(ml);
    endcase
    prod = 67'(ma) * 67'($signed({1'b0, h}));
    ds   = 70'(d) <<< FracBits;
    case (k)
      2'd2:    n = ds + (ds <<< 1) - 70'(prod);
      2'd3:    n = 70'(prod) - (ds <<< 1);
      default: n = 70'(prod);
    endcase
  end

  assign zmag  = z[127] ? 128'(-z) : 128'(z);
  assign trial = {rem, num[127]};
  assign diff  = trial - {1'b0, h};
  assign ge    = trial >= {1'b0, h};
  assign qfix  = neg ? -(num + 128'(rem != '0)) : num;
  assign r     = (z + (128'sd1 <<< (FracBits + 17))) >>> (FracBits + 18);
  assign fits  = (&r[127:CoefW-1]) || !(|r[127:CoefW-1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumRegs; i++) regs[i] <= '0;
      regs[RegXEnd] <= DataW'(1) << FracBits;
    end else if (cfg_hit) begin
      regs[cfg_index] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_ORDER;
    end else if (cfg_hit) begin
      state <= ST_ORDER;
    end else begin
      unique case (state)
        ST_ORDER: begin
          eq    <= eq_next;
          xl    <= flip ? regs[RegXEnd] : regs[RegXStart];
          yl    <= flip ? regs[RegYEnd] : regs[RegYStart];
          ml    <= flip ? regs[RegSlopeEnd] : regs[RegSlopeStart];
          xh    <= flip ? regs[RegXStart] : regs[RegXEnd];
          yh    <= flip ? regs[RegYStart] : regs[RegYEnd];
          mh    <= flip ? regs[RegSlopeStart] : regs[RegSlopeEnd];
          state <= eq_next ? ST_DONE : ST_LEN;
        end
        ST_LEN: begin
          h       <= hx[DataW-1:0];
          d       <= (DataW+1)'(yh) - (DataW+1)'(yl);
          len     <= len_next;
          coef[0] <= CoefW'(yl) <<< 2;
          k       <= 2'd1;
          state   <= ST_NUM;
        end
        ST_NUM: begin
          z     <= 128'(n) <<< 20;
          pass  <= '0;
          state <= ST_DLOAD;
        end
        ST_DLOAD: begin
          neg   <= z[127];
          num   <= zmag << len;
          rem   <= '0;
          cnt   <= '0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          num <= {num[126:0], ge};
          rem <= ge ? diff[DataW-1:0] : trial[DataW-1:0];
          cnt <= cnt + 1'b1;
          if (cnt == CntW'(DivSteps - 1)) state <= ST_DFIX;
        end
        ST_DFIX: begin
          z     <= $signed(qfix);
          pass  <= pass + 2'd1;
          state <= (2'(pass + 2'd1) == k) ? ST_ROUND : ST_DLOAD;
        end
        ST_ROUND: begin
          if (fits) coef[k] <= r[CoefW-1:0];
          else coef[k] <= r[127] ? {1'b1, {(CoefW-1){1'b0}}} : {1'b0, {(CoefW-1){1'b1}}};
          if (k == 2'd3) begin
            state <= ST_DONE;
          end else begin
            k     <= k + 2'd1;
            state <= ST_NUM;
          end
        end
        ST_DONE: state <= ST_DONE;
        default: state <= ST_ORDER;
      endcase
    end
  end

  assign seg.done = state == ST_DONE;
  assign seg.eq   = eq;
  assign seg.xl   = xl;
  assign seg.xh   = xh;
  assign seg.len  = len;
  assign seg.coef = coef;
endmodule
`default_nettype wire

// File: hw/rtl/che_horner.sv
// One Horner step over three stages: partial products, product sum, and
// shift-add with saturation. Depends on che_pkg.
`default_nettype none
module che_horner import che_pkg::*; (
  input  logic             clk,
  input  logic [2:0]       load,
  input  hstage_t          din,
  input  logic [CoefW-1:0] c,
  output hstage_t          dout
);
  logic signed [63:0]  pp11;
  logic signed [64:0]  pp10, pp01;
  logic [63:0]         pp00;
  logic signed [63:0]  mu;
  logic                minr, msat;
  logic signed [127:0] prod;
  logic signed [63:0]  su;
  logic                sinr, ssat;
  logic signed [127:0] s;
  logic                fits;

  always_ff @(posedge clk) begin
    if (load[0]) begin
      pp11 <= $signed(din.acc[63:32]) * $signed(din.u[63:32]);
      pp10 <= 65'($signed(din.acc[63:32])) * $signed({1'b0, din.u[31:0]});
      pp01 <= $signed({1'b0, din.acc[31:0]}) * 65'($signed(din.u[63:32]));
      pp00 <= din.acc[31:0] * din.u[31:0];
      mu   <= din.u;
      minr <= din.inr;
      msat <= din.sat;
    end
    if (load[1]) begin
      prod <= (128'(pp11) <<< 64) + (128'(pp10) <<< 32) + (128'(pp01) <<< 32)
            + $signed({64'd0, pp00});
      su   <= mu;
      sinr <= minr;
      ssat <= msat;
    end
    if (load[2]) begin
      if (fits) dout.acc <= s[CoefW-1:0];
      else dout.acc <= s[127] ? {1'b1, {(CoefW-1){1'b0}}} : {1'b0, {(CoefW-1){1'b1}}};
      dout.u   <= su;
      dout.inr <= sinr;
      dout.sat <= ssat || !fits;
    end
  end

  assign s    = (prod >>> 31) + 128'($signed(c));
  assign fits = (&s[127:CoefW-1]) || !(|s[127:CoefW-1]);
endmodule
`default_nettype wire

// File: hw/rtl/cubic_hermite_segment_eval.sv
// Top level of the cubic Hermite segment evaluator: register port, solver
// and the twelve-stage query pipeline. Depends on che_pkg, che_if, che_solve
// and che_horner.
// After reset or any register write the solver orders the endpoints and
// solves the cubic with one bit-serial divider, six divisions in all;
// queries are held off until it finishes (equal endpoint x values skip the
// solve). Then one query enters every cycle while the output is not stalled,
// passing through two front stages, three stages for each of the three
// 64x64 Horner multiplies, and the output register. Output stalls hold
// every stage that holds a valid query.
`default_nettype none
module cubic_hermite_segment_eval import che_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  query_if.sink              query,
  result_if.source           result,
  input  logic               cfg_we,
  input  logic [RegIdxW-1:0] cfg_index,
  input  logic [DataW-1:0]   cfg_data
);
  localparam int NumStages = 12;
  localparam int FinStage  = NumStages - 1;

  seg_t                  seg;
  logic [NumStages-1:0]  v, en;
  logic signed [DataW:0] t0;
  logic                  inr0;
  logic signed [63:0]    u_next;
  hstage_t               hs0, hs1, hs2, hs3;
  logic signed [64:0]    yr;
  logic                  yhi, ylo;

  che_solve u_solve (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .seg
  );

  always_comb begin
    en[FinStage] = !v[FinStage] || result.ready;
    for (int s = FinStage - 1; s >= 0; s--) en[s] = !v[s] || en[s+1];
  end

  assign query.ready = en[0] && seg.done;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= query.valid && query.ready;
      for (int s = 1; s < NumStages; s++) begin
        if (en[s]) v[s] <= v[s-1];
      end
    end
  end

  always_comb begin
    if (seg.len <= LenW'(31)) u_next = 64'(t0) <<< (LenW'(31) - seg.len);
    else u_next = 64'(t0) >>> 1;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      t0   <= (DataW+1)'(query.query_x) - (DataW+1)'(seg.xl);
      inr0 <= (query.query_x >= seg.xl) && (query.query_x <= seg.xh);
    end
    if (en[1]) begin
      hs0.acc <= $signed(seg.coef[3]);
      hs0.u   <= u_next;
      hs0.inr <= inr0;
      hs0.sat <= 1'b0;
    end
  end

  che_horner u_step2 (.clk, .load(en[4:2]),   .din(hs0), .c(seg.coef[2]), .dout(hs1));
  che_horner u_step1 (.clk, .load(en[7:5]),   .din(hs1), .c(seg.coef[1]), .dout(hs2));
  che_horner u_step0 (.clk, .load(en[10:8]),  .din(hs2), .c(seg.coef[0]), .dout(hs3));

  assign yr  = (65'(hs3.acc) + 65'sd2) >>> 2;
  assign yhi = yr > 65'sd2147483647;
  assign ylo = yr < -65'sd2147483648;

  always_ff @(posedge clk) begin
    if (en[FinStage]) begin
      result.in_range <= hs3.inr;
      if (seg.eq) begin
        result.value_y <= '0;
        result.status  <= StEqual;
      end else begin
        if (yhi) result.value_y <= {1'b0, {(DataW-1){1'b1}}};
        else if (ylo) result.value_y <= {1'b1, {(DataW-1){1'b0}}};
        else result.value_y <= yr[DataW-1:0];
        result.status <= (hs3.sat || yhi || ylo) ? StSat : StOk;
      end
    end
  end

  assign result.valid = v[FinStage];
endmodule
`default_nettype wire
